[rtl/stream_substring_replace_top_defines.svh]
// Assertion macros used by the substring replace sequencer.
`ifndef STREAM_SUBSTRING_REPLACE_TOP_DEFINES_SVH
`define STREAM_SUBSTRING_REPLACE_TOP_DEFINES_SVH

`ifndef SYNTH
// Clocked check, switched off while reset is held.
`define SSR_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("ssr assertion failed");
// Clocked check that also covers the reset cycles.
`define SSR_ASSERT_RST(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("ssr reset assertion failed");
`else
`define SSR_ASSERT(lbl, clk, rstn, prop)
`define SSR_ASSERT_RST(lbl, clk, prop)
`endif

`endif

[rtl/ssr_pkg.sv]
// Types and constants for the substring replace block.
package ssr_pkg;

    localparam int BYTE_W    = 8;
    localparam int WORD_W    = 64;
    localparam int LEN_W     = 4;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_PAT_BYTES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_LEN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REP_BYTES = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REP_LEN   = 2'd3;

    typedef struct packed {
        logic load;
        logic shift;
    } t_win_ctrl;

    typedef struct packed {
        logic              match;
        logic [BYTE_W-1:0] head;
    } t_win_stat;

endpackage

[rtl/ssr_ifs.sv]
// Stream and configuration channel interfaces of the substring replace block.
interface ssr_in_if;
    import ssr_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] in_char;
    logic              in_end;
    modport source (output valid, output in_char, output in_end, input ready);
    modport sink (input valid, input in_char, input in_end, output ready);
endinterface

interface ssr_out_if;
    import ssr_pkg::*;
    logic              valid;
    logic              ready;
    logic              has_char;
    logic [BYTE_W-1:0] out_char;
    logic              string_done;
    logic              run_last;
    modport source (output valid, output has_char, output out_char, output string_done,
                    output run_last, input ready);
    modport sink (input valid, input has_char, input out_char, input string_done,
                  input run_last, output ready);
endinterface

interface ssr_cfg_if;
    import ssr_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [WORD_W-1:0]    data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/ssr_cell.sv]
// One window cell: holds a pending byte and compares it with its pattern byte.
module ssr_cell (
    input  logic                      i_clk,
    input  ssr_pkg::t_win_ctrl        i_ctrl,
    input  logic                      i_sel,
    input  logic [ssr_pkg::BYTE_W-1:0] i_char,
    input  logic [ssr_pkg::BYTE_W-1:0] i_next,
    input  logic [ssr_pkg::BYTE_W-1:0] i_pat,
    input  logic                      i_active,
    output logic [ssr_pkg::BYTE_W-1:0] o_byte,
    output logic                      o_eq
);
    import ssr_pkg::*;

    logic [BYTE_W-1:0] r_byte;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load && i_sel) begin
            r_byte <= i_char;
        end else if (i_ctrl.shift) begin
            r_byte <= i_next;
        end
    end

    assign o_byte = r_byte;
    // cells beyond the pattern length do not take part in the match
    assign o_eq   = !i_active || (r_byte == i_pat);

endmodule

[rtl/ssr_window.sv]
// Row of window cells, oldest byte in cell zero, shifting towards it.
module ssr_window #(
    parameter int MAX_PATTERN = 8
) (
    input  logic                       i_clk,
    input  ssr_pkg::t_win_ctrl         i_ctrl,
    input  logic [MAX_PATTERN-1:0]     i_load_sel,
    input  logic [ssr_pkg::BYTE_W-1:0] i_char,
    input  logic [ssr_pkg::WORD_W-1:0] i_pat_bytes,
    input  logic [ssr_pkg::LEN_W-1:0]  i_plen,
    output ssr_pkg::t_win_stat         o_stat
);
    import ssr_pkg::*;

    logic [BYTE_W-1:0]      w_byte [MAX_PATTERN];
    logic [BYTE_W-1:0]      w_next [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] w_eq;

    for (genvar g = 0; g < MAX_PATTERN; g++) begin : g_cell
        if (g == MAX_PATTERN - 1) begin : g_tail
            assign w_next[g] = w_byte[g];
        end else begin : g_mid
            assign w_next[g] = w_byte[g+1];
        end

        ssr_cell u_cell (
            .i_clk    (i_clk),
            .i_ctrl   (i_ctrl),
            .i_sel    (i_load_sel[g]),
            .i_char   (i_char),
            .i_next   (w_next[g]),
            .i_pat    (i_pat_bytes[BYTE_W*g +: BYTE_W]),
            .i_active (LEN_W'(g) < i_plen),
            .o_byte   (w_byte[g]),
            .o_eq     (w_eq[g])
        );
    end

    assign o_stat.match = &w_eq;
    assign o_stat.head  = w_byte[0];

endmodule

[rtl/ssr_seq.sv]
// Sequencer: steps the cell row, emits bytes and drives the output register.
`include "stream_substring_replace_top_defines.svh"

module ssr_seq #(
    parameter int MAX_PATTERN = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    ssr_in_if.sink                     i_in,
    ssr_out_if.source                  o_out,
    input  logic [ssr_pkg::LEN_W-1:0]  i_plen,
    input  logic [ssr_pkg::LEN_W-1:0]  i_rlen,
    input  logic [ssr_pkg::WORD_W-1:0] i_repl_bytes,
    input  ssr_pkg::t_win_stat         i_stat,
    output ssr_pkg::t_win_ctrl         o_ctrl,
    output logic [MAX_PATTERN-1:0]     o_load_sel
);
    import ssr_pkg::*;

    localparam int CNT_W = $clog2(MAX_PATTERN + 1);
    localparam int KW    = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_PROC = 2'd1;
    localparam logic [1:0] S_REPL = 2'd2;

    logic [1:0]        r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              r_end, n_end;
    logic [KW-1:0]     r_k, n_k;
    logic              r_hold_valid, n_hold_valid;
    logic [BYTE_W-1:0] r_hold, n_hold;
    logic              r_ov, n_ov;
    logic              r_has, n_has;
    logic [BYTE_W-1:0] r_char, n_char;
    logic              r_done, n_done;
    logic              r_last, n_last;

    t_win_ctrl         w_ctrl;
    logic [LEN_W-1:0]  w_cnt;
    logic              w_pass, w_at_plen, w_want_emit;
    logic              w_out_free, w_can_prod, w_prod, w_flush_out;
    logic [BYTE_W-1:0] w_prod_byte;

    assign w_cnt       = LEN_W'(r_count);
    assign w_pass      = (i_plen == '0) || (i_rlen > i_plen);
    assign w_at_plen   = (w_cnt == i_plen);
    assign w_want_emit = w_pass ? (r_count != '0)
                                : ((w_cnt > i_plen) || w_at_plen || (r_end && r_count != '0));
    assign w_out_free  = !r_ov || o_out.ready;
    assign w_can_prod  = !r_hold_valid || w_out_free;
    assign w_flush_out = r_hold_valid || r_end;

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_end        = r_end;
        n_k          = r_k;
        n_hold       = r_hold;
        n_hold_valid = r_hold_valid;
        n_ov         = o_out.ready ? 1'b0 : r_ov;
        n_has        = r_has;
        n_char       = r_char;
        n_done       = r_done;
        n_last       = r_last;
        w_ctrl       = '0;
        w_prod       = 1'b0;
        w_prod_byte  = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    w_ctrl.load = 1'b1;
                    n_count     = r_count + CNT_W'(1);
                    n_end       = i_in.in_end;
                    n_state     = S_PROC;
                end
            end
            S_PROC: begin
                if (!w_pass && w_at_plen && i_stat.match) begin
                    // drop the matched window; replacement follows if any
                    n_count = '0;
                    n_k     = '0;
                    if (i_rlen != '0) begin
                        n_state = S_REPL;
                    end
                end else if (w_want_emit) begin
                    if (w_can_prod) begin
                        w_prod       = 1'b1;
                        w_prod_byte  = i_stat.head;
                        w_ctrl.shift = 1'b1;
                        n_count      = r_count - CNT_W'(1);
                    end
                end else if (!w_flush_out || w_out_free) begin
                    // release the held byte as the last beat of this item
                    if (w_flush_out) begin
                        n_ov   = 1'b1;
                        n_has  = r_hold_valid;
                        n_char = r_hold_valid ? r_hold : '0;
                        n_done = r_end;
                        n_last = 1'b1;
                    end
                    n_hold_valid = 1'b0;
                    n_state      = S_IDLE;
                end
            end
            S_REPL: begin
                if (w_can_prod) begin
                    w_prod      = 1'b1;
                    w_prod_byte = i_repl_bytes[BYTE_W*r_k +: BYTE_W];
                    if (LEN_W'(r_k) == i_rlen - LEN_W'(1)) begin
                        n_state = S_PROC;
                    end else begin
                        n_k = r_k + KW'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        // hold one byte back so the last beat of an item can be flagged
        if (w_prod) begin
            if (r_hold_valid) begin
                n_ov   = 1'b1;
                n_has  = 1'b1;
                n_char = r_hold;
                n_done = 1'b0;
                n_last = 1'b0;
            end
            n_hold       = w_prod_byte;
            n_hold_valid = 1'b1;
        end
    end

    always_comb begin
        o_load_sel = '0;
        for (int i = 0; i < MAX_PATTERN; i++) begin
            o_load_sel[i] = (w_cnt == LEN_W'(i));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_hold_valid <= 1'b0;
            r_ov         <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_hold_valid <= n_hold_valid;
            r_ov         <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_end  <= n_end;
        r_k    <= n_k;
        r_hold <= n_hold;
        r_has  <= n_has;
        r_char <= n_char;
        r_done <= n_done;
        r_last <= n_last;
    end

    assign o_ctrl            = w_ctrl;
    assign i_in.ready        = (r_state == S_IDLE);
    assign o_out.valid       = r_ov;
    assign o_out.has_char    = r_has;
    assign o_out.out_char    = r_char;
    assign o_out.string_done = r_done;
    assign o_out.run_last    = r_last;

    `SSR_ASSERT(a_idle_room, i_clk, i_rst_n, (r_state == S_IDLE) |-> (w_cnt < LEN_W'(MAX_PATTERN)))
    `SSR_ASSERT(a_idle_no_hold, i_clk, i_rst_n, (r_state == S_IDLE) |-> !r_hold_valid)
    `SSR_ASSERT(a_shift_nonempty, i_clk, i_rst_n, w_ctrl.shift |-> (r_count != '0))
    `SSR_ASSERT(a_repl_range, i_clk, i_rst_n, (r_state == S_REPL) |-> (LEN_W'(r_k) < i_rlen))
    `SSR_ASSERT(a_end_empties, i_clk, i_rst_n, (r_state == S_PROC && n_state == S_IDLE && r_end) |=> (r_count == '0))
    `SSR_ASSERT_RST(a_reset_idle, i_clk, !i_rst_n |=> (r_state == S_IDLE) && !r_ov)

endmodule

[rtl/stream_substring_replace_top.sv]
// Top level of the streaming substring find-and-replace block.
// Bytes arrive one per beat on i_in and come out rewritten on o_out, each leftmost
// non-overlapping pattern occurrence swapped for the replacement; a pattern length of
// zero, or a replacement longer than the pattern, passes bytes through unchanged. An
// input beat is taken only while the sequencer is idle; it then holds the block until it
// has released its bytes (and the replacement when it completes a match), since a single
// sequencer steps the row of window cells one byte per cycle while o_out is not stalled.
// Backpressure on o_out stalls it. The end-of-string beat flushes the window; if it
// releases nothing, one beat with has_char low marks the end. Configuration writes on
// i_cfg are always accepted and must only be issued while the block is idle.
module stream_substring_replace_top #(
    parameter int MAX_PATTERN = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ssr_in_if.sink    i_in,
    ssr_out_if.source o_out,
    ssr_cfg_if.sink   i_cfg
);
    import ssr_pkg::*;

    logic [WORD_W-1:0] r_pat_bytes;
    logic [LEN_W-1:0]  r_pat_len;
    logic [WORD_W-1:0] r_rep_bytes;
    logic [LEN_W-1:0]  r_rep_len;

    logic [LEN_W-1:0]       w_plen, w_rlen;
    t_win_ctrl              w_ctrl;
    t_win_stat              w_stat;
    logic [MAX_PATTERN-1:0] w_load_sel;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_bytes <= '0;
            r_pat_len   <= '0;
            r_rep_bytes <= '0;
            r_rep_len   <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_PAT_BYTES: r_pat_bytes <= i_cfg.data;
                CFG_PAT_LEN:   r_pat_len   <= i_cfg.data[LEN_W-1:0];
                CFG_REP_BYTES: r_rep_bytes <= i_cfg.data;
                CFG_REP_LEN:   r_rep_len   <= i_cfg.data[LEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // saturate lengths to the window depth
    assign w_plen = (r_pat_len > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN) : r_pat_len;
    assign w_rlen = (r_rep_len > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN) : r_rep_len;

    ssr_window #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_window (
        .i_clk       (i_clk),
        .i_ctrl      (w_ctrl),
        .i_load_sel  (w_load_sel),
        .i_char      (i_in.in_char),
        .i_pat_bytes (r_pat_bytes),
        .i_plen      (w_plen),
        .o_stat      (w_stat)
    );

    ssr_seq #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .o_out        (o_out),
        .i_plen       (w_plen),
        .i_rlen       (w_rlen),
        .i_repl_bytes (r_rep_bytes),
        .i_stat       (w_stat),
        .o_ctrl       (w_ctrl),
        .o_load_sel   (w_load_sel)
    );

endmodule
